// File: hw/rtl/crrl_pkg.sv
// Chained range remap lookup: shared constants, payload and command types.
// Used by every module of the block; depends on nothing.

package crrl_pkg;

	localparam int NUM_STAGES        = 7;
	localparam int ENTRIES_PER_STAGE = 64;
	localparam int VALUE_BITS        = 32;

	localparam int TOTAL_ENTRIES = NUM_STAGES * ENTRIES_PER_STAGE;
	localparam int ADDR_W        = $clog2(TOTAL_ENTRIES);
	localparam int STAGE_CNT_W   = $clog2(NUM_STAGES + 1);
	localparam int ENT_CNT_W     = $clog2(ENTRIES_PER_STAGE + 1);

	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam int STAGE_FIELD_W = 3;
	localparam int SLOT_FIELD_W  = 6;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic [STAGE_FIELD_W-1:0]  stage;
		logic [SLOT_FIELD_W-1:0]   slot;
		logic [VALUE_BITS-1:0]     src_start;
		logic [VALUE_BITS-1:0]     dst_start;
		logic [VALUE_BITS-1:0]     span_length;
		logic [VALUE_BITS-1:0]     key;
	} req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] location;
		logic [VALUE_BITS-1:0] min_location;
		logic                  overflowed;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_LOOKUP,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] src;
		logic [VALUE_BITS-1:0] dst;
		logic [VALUE_BITS-1:0] span;
	} entry_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [ADDR_W-1:0]     addr;
		entry_t                entry;
		logic [VALUE_BITS-1:0] key;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_WIPE,
		ST_IDLE,
		ST_SCAN,
		ST_MAP,
		ST_FINISH
	} state_t;

endpackage

// File: hw/rtl/crrl_front.sv
// Front end: accepts request transactions and classifies them into commands.
// Depends on crrl_pkg.

module crrl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hold,
	input  crrl_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_ready,
	output crrl_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_ready
);

	crrl_pkg::cmd_t cmd_d;
	crrl_pkg::cmd_t cmd_s1;
	logic           valid_s1;
	logic           target_ok;
	logic           take;

	assign req_ready = !hold && (!valid_s1 || cmd_ready);
	assign take      = req_valid && req_ready;
	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

	always_comb begin
		target_ok = (int'(req.stage) < crrl_pkg::NUM_STAGES)
			&& (int'(req.slot) < crrl_pkg::ENTRIES_PER_STAGE);
		cmd_d.addr = crrl_pkg::ADDR_W'(int'(req.stage) * crrl_pkg::ENTRIES_PER_STAGE
			+ int'(req.slot));
		cmd_d.entry.src  = req.src_start;
		cmd_d.entry.dst  = req.dst_start;
		cmd_d.entry.span = req.span_length;
		cmd_d.key        = req.key;
		unique case (req.opcode)
			crrl_pkg::OP_WRITE:  cmd_d.kind = target_ok ? crrl_pkg::CMD_WRITE : crrl_pkg::CMD_NOP;
			crrl_pkg::OP_LOOKUP: cmd_d.kind = crrl_pkg::CMD_LOOKUP;
			crrl_pkg::OP_CLEAR:  cmd_d.kind = crrl_pkg::CMD_CLEAR;
			crrl_pkg::OP_NONE:   cmd_d.kind = crrl_pkg::CMD_NOP;
			default:             cmd_d.kind = crrl_pkg::CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: hw/rtl/crrl_cmd_fifo.sv
// Short command queue between the front end and the execution back end.
// Depends on crrl_pkg.

module crrl_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  crrl_pkg::cmd_t push_cmd,
	input  logic          push_valid,
	output logic          push_ready,
	output crrl_pkg::cmd_t pop_cmd,
	output logic          pop_valid,
	input  logic          pop_ready
);

	crrl_pkg::cmd_t                   slots_q [crrl_pkg::QUEUE_DEPTH];
	logic [crrl_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [crrl_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [crrl_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                             push;
	logic                             pop;

	assign push_ready = count_q != crrl_pkg::QUEUE_CNT_W'(crrl_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == crrl_pkg::QUEUE_PTR_W'(crrl_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == crrl_pkg::QUEUE_PTR_W'(crrl_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hw/rtl/crrl_back.sv
// Back end: table memory, per-stage range scan, remap and response register.
// Depends on crrl_pkg.

module crrl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  crrl_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output crrl_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output logic          wiping
);

	localparam int VB = crrl_pkg::VALUE_BITS;
	localparam int AW = crrl_pkg::ADDR_W;

	crrl_pkg::entry_t mem [crrl_pkg::TOTAL_ENTRIES];

	crrl_pkg::state_t state_q, state_d;

	logic [AW-1:0]                    addr_q;
	logic [crrl_pkg::ENT_CNT_W-1:0]   ent_q;
	logic [crrl_pkg::STAGE_CNT_W-1:0] stg_q;
	logic                             rd_v_s1;
	logic                             rd_last_s1;
	crrl_pkg::entry_t                 rdata_s1;
	logic [VB-1:0]                    key_q;
	logic                             found_q;
	logic [VB-1:0]                    best_src_q;
	logic [VB-1:0]                    best_dst_q;
	logic [VB-1:0]                    best_off_q;
	logic                             wrapped_q;
	logic [VB-1:0]                    min_q;
	crrl_pkg::rsp_t                   rsp_q;
	logic                             rsp_valid_q;

	logic             free;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	crrl_pkg::entry_t mem_wdata;
	logic             issue;
	logic             start;
	logic             map_step;
	logic             rsp_load;
	crrl_pkg::rsp_t   rsp_d;
	logic             min_load;
	logic [VB-1:0]    min_d;
	logic [VB-1:0]    off;
	logic             hit;
	logic             better;
	logic [VB:0]      sum;
	logic [VB-1:0]    new_min;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign wiping    = state_q == crrl_pkg::ST_WIPE;
	assign free      = !rsp_valid_q || rsp_ready;

	// span test and lowest-source-start selection, one entry per cycle
	assign off    = key_q - rdata_s1.src;
	assign hit    = rd_v_s1 && (rdata_s1.span != '0) && (key_q >= rdata_s1.src)
		&& (off < rdata_s1.span);
	assign better = hit && (!found_q || (rdata_s1.src < best_src_q));

	assign sum     = {1'b0, best_dst_q} + {1'b0, best_off_q};
	assign new_min = (key_q < min_q) ? key_q : min_q;

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		issue     = 1'b0;
		start     = 1'b0;
		map_step  = 1'b0;
		rsp_load  = 1'b0;
		rsp_d     = '{location: '0, min_location: min_q, overflowed: 1'b0};
		min_load  = 1'b0;
		min_d     = min_q;
		unique case (state_q)
			crrl_pkg::ST_WIPE: begin
				mem_we = 1'b1;
				if (addr_q == AW'(crrl_pkg::TOTAL_ENTRIES - 1)) begin
					state_d = crrl_pkg::ST_IDLE;
				end
			end
			crrl_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						crrl_pkg::CMD_LOOKUP: begin
							cmd_ready = 1'b1;
							start     = 1'b1;
							state_d   = crrl_pkg::ST_SCAN;
						end
						crrl_pkg::CMD_WRITE: begin
							if (free) begin
								cmd_ready = 1'b1;
								mem_we    = 1'b1;
								mem_waddr = cmd.addr;
								mem_wdata = cmd.entry;
								rsp_load  = 1'b1;
							end
						end
						crrl_pkg::CMD_CLEAR: begin
							if (free) begin
								cmd_ready          = 1'b1;
								min_load           = 1'b1;
								min_d              = '1;
								rsp_load           = 1'b1;
								rsp_d.min_location = '1;
							end
						end
						crrl_pkg::CMD_NOP: begin
							if (free) begin
								cmd_ready = 1'b1;
								rsp_load  = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			crrl_pkg::ST_SCAN: begin
				issue = ent_q < crrl_pkg::ENT_CNT_W'(crrl_pkg::ENTRIES_PER_STAGE);
				if (rd_v_s1 && rd_last_s1) begin
					state_d = crrl_pkg::ST_MAP;
				end
			end
			crrl_pkg::ST_MAP: begin
				map_step = 1'b1;
				if (stg_q == crrl_pkg::STAGE_CNT_W'(crrl_pkg::NUM_STAGES - 1)) begin
					state_d = crrl_pkg::ST_FINISH;
				end else begin
					state_d = crrl_pkg::ST_SCAN;
				end
			end
			crrl_pkg::ST_FINISH: begin
				if (free) begin
					rsp_load = 1'b1;
					min_load = 1'b1;
					min_d    = new_min;
					rsp_d    = '{location: key_q, min_location: new_min, overflowed: wrapped_q};
					state_d  = crrl_pkg::ST_IDLE;
				end
			end
			default: state_d = crrl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crrl_pkg::ST_WIPE;
			addr_q      <= '0;
			ent_q       <= '0;
			stg_q       <= '0;
			rd_v_s1     <= 1'b0;
			rd_last_s1  <= 1'b0;
			found_q     <= 1'b0;
			wrapped_q   <= 1'b0;
			min_q       <= '1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_v_s1    <= issue;
			rd_last_s1 <= issue
				&& (ent_q == crrl_pkg::ENT_CNT_W'(crrl_pkg::ENTRIES_PER_STAGE - 1));
			if (state_q == crrl_pkg::ST_WIPE) begin
				addr_q <= (state_d == crrl_pkg::ST_WIPE) ? addr_q + 1'b1 : '0;
			end else if (start) begin
				addr_q <= '0;
			end else if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
			if (start || map_step) begin
				ent_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					ent_q <= ent_q + 1'b1;
				end
				if (better) begin
					found_q <= 1'b1;
				end
			end
			if (start) begin
				stg_q     <= '0;
				wrapped_q <= 1'b0;
			end else if (map_step) begin
				stg_q     <= stg_q + 1'b1;
				wrapped_q <= wrapped_q | (found_q & sum[VB]);
			end
			if (min_load) begin
				min_q <= min_d;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= cmd.key;
		end else if (map_step && found_q) begin
			key_q <= sum[VB-1:0];
		end
		if (better) begin
			best_src_q <= rdata_s1.src;
			best_dst_q <= rdata_s1.dst;
			best_off_q <= off;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[addr_q];
	end

endmodule

// File: hw/rtl/chained_range_remap_lookup.sv
// Top level of the chained range remap lookup: front end, command queue, back end.
// Depends on crrl_pkg, crrl_front, crrl_cmd_fifo and crrl_back.
//
// Each request transaction yields exactly one response, in order. Writes, clears and
// unused opcodes complete in the back end without leaving ST_IDLE; a lookup walks
// the tables one after another: for each table the back end scans the table memory
// one entry per cycle (ST_SCAN), then takes a remap step (ST_MAP), and ST_FINISH
// loads the response. Requests are queued ahead of the back end and keep being
// accepted while a response waits, until the front end register and command queue are
// full. After reset the table memory is wiped to zero; no request is accepted during the wipe.

module chained_range_remap_lookup (
	input  logic          clk,
	input  logic          arst_n,
	input  crrl_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_ready,
	output crrl_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_ready
);

	crrl_pkg::cmd_t front_cmd;
	logic           front_valid;
	logic           front_ready;
	crrl_pkg::cmd_t queue_cmd;
	logic           queue_valid;
	logic           queue_ready;
	logic           wiping;

	crrl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (wiping),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	crrl_cmd_fifo u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (queue_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready)
	);

	crrl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queue_cmd),
		.cmd_valid (queue_valid),
		.cmd_ready (queue_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.wiping    (wiping)
	);

	a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (!arst_n)
		wiping |-> !req_ready)
		else $error("request accepted during table wipe");

	a_no_rsp_in_wipe: assert property (@(posedge clk) disable iff (!arst_n)
		wiping |-> !rsp_valid)
		else $error("response present during table wipe");

	a_min_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.min_location <= rsp.location)
			|| ((rsp.location == '0) && !rsp.overflowed))
		else $error("running minimum above reported location");

endmodule

// File: test/tb.sv
// Testbench for chained_range_remap_lookup: directed and random request traffic, with
// every response checked in order against an in-bench translation-table predictor.
// Depends on crrl_pkg and the chained_range_remap_lookup RTL.
`timescale 1ns / 100ps

module tb;

	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 600;
	localparam int RANDOM_ITEMS = 2000;
	localparam int VB           = crrl_pkg::VALUE_BITS;

	logic           clk;
	logic           arst_n;
	crrl_pkg::req_t req;
	logic           req_valid;
	logic           req_ready;
	crrl_pkg::rsp_t rsp;
	logic           rsp_valid;
	logic           rsp_ready;

	chained_range_remap_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	// predictor state
	logic [VB-1:0] tbl_src [crrl_pkg::TOTAL_ENTRIES] = '{default: '0};
	logic [VB-1:0] tbl_dst [crrl_pkg::TOTAL_ENTRIES] = '{default: '0};
	logic [VB-1:0] tbl_len [crrl_pkg::TOTAL_ENTRIES] = '{default: '0};
	logic [VB-1:0] min_seen = '1;

	crrl_pkg::rsp_t awaited_rsp [$];
	crrl_pkg::rsp_t want_rsp;
	int             mismatches = 0;
	int             idle_cycles = 0;
	bit             idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [VB-1:0] remap_stage(int st, logic [VB-1:0] k,
			inout bit wrapped);
		bit            found;
		int            best;
		int            idx;
		logic [VB-1:0] best_src;
		logic [VB:0]   sum;
		found    = 1'b0;
		best     = 0;
		best_src = '0;
		for (int e = 0; e < crrl_pkg::ENTRIES_PER_STAGE; e++) begin
			idx = st * crrl_pkg::ENTRIES_PER_STAGE + e;
			if (tbl_len[idx] != 0 && k >= tbl_src[idx] && (k - tbl_src[idx]) < tbl_len[idx]) begin
				if (!found || tbl_src[idx] < best_src) begin
					found    = 1'b1;
					best_src = tbl_src[idx];
					best     = idx;
				end
			end
		end
		if (!found)
			return k;
		sum = {1'b0, tbl_dst[best]} + {1'b0, k - best_src};
		if (sum[VB])
			wrapped = 1'b1;
		return sum[VB-1:0];
	endfunction

	function automatic crrl_pkg::rsp_t compute_response(crrl_pkg::req_t r);
		crrl_pkg::rsp_t o;
		logic [VB-1:0]  loc;
		bit             wr;
		int             idx;
		o  = '0;
		wr = 1'b0;
		unique case (r.opcode)
			crrl_pkg::OP_WRITE: begin
				if (r.stage < crrl_pkg::NUM_STAGES && r.slot < crrl_pkg::ENTRIES_PER_STAGE) begin
					idx = int'(r.stage) * crrl_pkg::ENTRIES_PER_STAGE + int'(r.slot);
					tbl_src[idx] = r.src_start;
					tbl_dst[idx] = r.dst_start;
					tbl_len[idx] = r.span_length;
				end
			end
			crrl_pkg::OP_LOOKUP: begin
				loc = r.key;
				for (int s = 0; s < crrl_pkg::NUM_STAGES; s++)
					loc = remap_stage(s, loc, wr);
				if (loc < min_seen)
					min_seen = loc;
				o.location   = loc;
				o.overflowed = wr;
			end
			crrl_pkg::OP_CLEAR: begin
				min_seen = '1;
			end
			default: ;
		endcase
		o.min_location = min_seen;
		return o;
	endfunction

	function automatic crrl_pkg::req_t noise_req(crrl_pkg::opcode_t op);
		crrl_pkg::req_t r;
		r.opcode      = op;
		r.stage       = crrl_pkg::STAGE_FIELD_W'($urandom_range(0, 7));
		r.slot        = crrl_pkg::SLOT_FIELD_W'($urandom_range(0, 63));
		r.src_start   = $urandom;
		r.dst_start   = $urandom;
		r.span_length = $urandom;
		r.key         = $urandom;
		return r;
	endfunction

	task automatic send_item(crrl_pkg::req_t r);
		int gap;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		awaited_rsp.insert(awaited_rsp.size(), compute_response(r));
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_entry(int st, int sl, logic [VB-1:0] src,
			logic [VB-1:0] dst, logic [VB-1:0] span);
		crrl_pkg::req_t r;
		r             = noise_req(crrl_pkg::OP_WRITE);
		r.stage       = crrl_pkg::STAGE_FIELD_W'(st);
		r.slot        = crrl_pkg::SLOT_FIELD_W'(sl);
		r.src_start   = src;
		r.dst_start   = dst;
		r.span_length = span;
		send_item(r);
	endtask

	task automatic lookup_key(logic [VB-1:0] k);
		crrl_pkg::req_t r;
		r     = noise_req(crrl_pkg::OP_LOOKUP);
		r.key = k;
		send_item(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_basic_remap();
		write_entry(0, 0, 32'd100, 32'd200, 32'd10);
		lookup_key(32'd100);
		lookup_key(32'd109);
		lookup_key(32'd110);
		lookup_key(32'd99);
	endtask

	// lowest source start wins, ties go to the lowest slot, identity still wins
	task automatic test_match_priority();
		write_entry(1, 5, 32'd1000, 32'd1000, 32'd100);
		write_entry(1, 2, 32'd1050, 32'd5000, 32'd100);
		write_entry(1, 9, 32'd1000, 32'd7000, 32'd20);
		lookup_key(32'd1060);
		lookup_key(32'd1010);
		lookup_key(32'd1120);
	endtask

	task automatic test_wrap_and_edges();
		write_entry(2, 63, 32'hFFFF_0000, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		write_entry(3, 0, 32'd0, 32'd77, 32'd0);
		lookup_key(32'hFFFF_FFFF);
		lookup_key(32'd5);
		lookup_key(32'd0);
	endtask

	task automatic test_misc_ops();
		write_entry(7, 0, 32'd0, 32'd1234, 32'hFFFF_FFFF);
		lookup_key(32'd0);
		send_item(noise_req(crrl_pkg::OP_NONE));
		send_item(noise_req(crrl_pkg::OP_CLEAR));
		lookup_key(32'hFFFF_FFFF);
		send_item(noise_req(crrl_pkg::OP_CLEAR));
	endtask

	task automatic test_random_traffic(int n);
		int            op;
		int            m;
		int            idx;
		logic [VB-1:0] k;
		logic [VB-1:0] off_max;
		for (int i = 0; i < n; i++) begin
			idle_on = (i >= 300);
			if (i == n / 2)
				drain();
			op = $urandom_range(0, 99);
			if (op < 40) begin
				m = $urandom_range(0, 9);
				idx = ($urandom_range(0, 15) == 0) ? 7
					: $urandom_range(0, crrl_pkg::NUM_STAGES - 1);
				if (m <= 5)
					write_entry(idx, $urandom_range(0, 63), $urandom_range(0, 4095),
						$urandom_range(0, 4095), $urandom_range(1, 512));
				else if (m == 6)
					write_entry(idx, $urandom_range(0, 63), $urandom, $urandom, 32'd0);
				else if (m == 7)
					write_entry(idx, $urandom_range(0, 63), $urandom_range(0, 4095),
						$urandom_range(32'hFFFF_F000, 32'hFFFF_FFFF), $urandom_range(1, 8192));
				else
					write_entry(idx, $urandom_range(0, 63), $urandom, $urandom, $urandom);
			end else if (op < 90) begin
				m = $urandom_range(0, 9);
				if (m <= 4) begin
					idx = $urandom_range(0, crrl_pkg::ENTRIES_PER_STAGE - 1);
					if (tbl_len[idx] != 0) begin
						off_max = (tbl_len[idx] > 4096) ? 32'd4095 : tbl_len[idx] - 1;
						k = tbl_src[idx] + $urandom_range(0, off_max);
					end else begin
						k = $urandom_range(0, 4607);
					end
				end else if (m <= 7) begin
					k = $urandom_range(0, 4607);
				end else if (m == 8) begin
					k = $urandom;
				end else begin
					k = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
				end
				lookup_key(k);
			end else if (op < 95) begin
				send_item(noise_req(crrl_pkg::OP_CLEAR));
			end else begin
				send_item(noise_req(crrl_pkg::OP_NONE));
			end
		end
	endtask

	// response drive: short stalls mostly, a few long ones
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready  <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, actual %h", $time, rsp);
				mismatches++;
			end else begin
				want_rsp = awaited_rsp.pop_front();
				if (rsp.location !== want_rsp.location) begin
					$display("%0t: location mismatch: expected %h, actual %h",
						$time, want_rsp.location, rsp.location);
					mismatches++;
				end
				if (rsp.min_location !== want_rsp.min_location) begin
					$display("%0t: min_location mismatch: expected %h, actual %h",
						$time, want_rsp.min_location, rsp.min_location);
					mismatches++;
				end
				if (rsp.overflowed !== want_rsp.overflowed) begin
					$display("%0t: overflowed mismatch: expected %b, actual %b",
						$time, want_rsp.overflowed, rsp.overflowed);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_remap();
		test_match_priority();
		drain();
		test_wrap_and_edges();
		test_misc_ops();
		test_random_traffic(RANDOM_ITEMS);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
